/* design/lcg_pkg.sv */
// Shared types, constants and helpers for the line color gradient block.
`default_nettype none

package lcg_pkg;

	localparam int COLOR_BITS = 32;
	localparam int CH_BITS    = 8;
	localparam int CH_COUNT   = 3;
	localparam int QUO_BITS   = 8;

	localparam logic [CH_BITS-1:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [CH_BITS-1:0] CH_MAX       = 8'hFF;
	localparam logic [CH_BITS-1:0] CH_MIN       = 8'h00;

	typedef logic [COLOR_BITS-1:0] color_t;

	// Word that replaces the blend result when en is set.
	typedef struct packed {
		logic   en;
		color_t word;
	} bypass_t;

	// Low bit of channel c: R first, then G, then B.
	function automatic int chan_lsb(input int c);
		chan_lsb = COLOR_BITS - CH_BITS * (c + 1);
	endfunction

endpackage

`default_nettype wire

/* design/lcg_if.sv */
// Valid/ready channel interfaces for pixel requests and colored results.
`default_nettype none

interface lcg_in_if #(parameter int COORD_BITS = 16) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;
	lcg_pkg::color_t              start_color;
	lcg_pkg::color_t              end_color;

	modport source (
		output valid, pixel_x, pixel_y, start_x, start_y, end_x, end_y,
		       start_color, end_color,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, start_x, start_y, end_x, end_y,
		       start_color, end_color,
		output ready
	);
endinterface

interface lcg_out_if ();
	logic            valid;
	logic            ready;
	lcg_pkg::color_t pixel_color;

	modport source (output valid, pixel_color, input ready);
	modport sink (input valid, pixel_color, output ready);
endinterface

`default_nettype wire

/* design/line_color_gradient.sv */
// Top level of the line color gradient: pixel request in, interpolated RGBA out.
//
// Usage:
//   pixel_in carries one word per pixel: the pixel's coordinates, the two
//   segment endpoints and the two endpoint RGBA colors. pixel_out returns one
//   word per request, in order, holding the interpolated RGBA color.
//   Equal endpoint colors pass the start color through unchanged. Otherwise
//   R, G and B are blended linearly along the major axis, truncated toward
//   zero and clamped to 0..255; alpha is 0xFF. Zero length along the major
//   axis yields the end color's R, G and B with alpha 0xFF.
// Depth: 13 register stages (2 front, 2 blend, 8 divider, 1 output).
// Throughput: one word per cycle while pixel_out keeps taking words. The
//   divider is one quotient bit per stage, so the 8-bit quotient sets the
//   pipeline depth, not the rate.
// Reset: arst_n clears every valid bit at once; the pipeline is empty and
//   ready in the first cycle after release.
// Stall: when pixel_out is not taken, the output word holds and each stage
//   advances only into an empty slot, so bubbles close up and pixel_in stays
//   ready until every stage is full.
`default_nettype none

module line_color_gradient #(
	parameter int COORD_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	lcg_in_if.sink        pixel_in,
	lcg_out_if.source     pixel_out
);

	localparam int NCH = lcg_pkg::CH_COUNT;

	// front -> blend
	logic                              fb_valid, fb_ready;
	logic [COORD_BITS:0]               fb_dist;
	logic signed [COORD_BITS+1:0]      fb_pos;
	logic [lcg_pkg::CH_BITS-1:0]       fb_start [NCH];
	logic signed [lcg_pkg::CH_BITS:0]  fb_diff [NCH];
	lcg_pkg::bypass_t                  fb_byp;

	// blend -> divider
	logic                              bd_valid, bd_ready;
	logic [COORD_BITS+8:0]             bd_rem [NCH];
	logic [NCH-1:0]                    bd_under, bd_over;
	logic [COORD_BITS:0]               bd_dist;
	logic                              bd_blend_n;
	lcg_pkg::bypass_t                  bd_byp;
	logic                              dv_valid;
	lcg_pkg::color_t                   dv_color;

	// Find the major axis and the signed position along it.
	lcg_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (pixel_in.valid),
		.in_ready    (pixel_in.ready),
		.pixel_x     (pixel_in.pixel_x),
		.pixel_y     (pixel_in.pixel_y),
		.start_x     (pixel_in.start_x),
		.start_y     (pixel_in.start_y),
		.end_x       (pixel_in.end_x),
		.end_y       (pixel_in.end_y),
		.start_color (pixel_in.start_color),
		.end_color   (pixel_in.end_color),
		.out_valid   (fb_valid),
		.out_ready   (fb_ready),
		.dist_mag    (fb_dist),
		.pos_adj     (fb_pos),
		.start_ch    (fb_start),
		.diff_ch     (fb_diff),
		.bypass      (fb_byp)
	);

	// Build the blend numerator per channel and flag out-of-range results.
	lcg_blend #(.COORD_BITS(COORD_BITS)) u_blend (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (fb_valid),
		.in_ready      (fb_ready),
		.dist_mag      (fb_dist),
		.pos_adj       (fb_pos),
		.start_ch      (fb_start),
		.diff_ch       (fb_diff),
		.bypass        (fb_byp),
		.out_valid     (bd_valid),
		.out_ready     (bd_ready),
		.rem           (bd_rem),
		.under         (bd_under),
		.over          (bd_over),
		.dist_out      (bd_dist),
		.dist_unused_n (bd_blend_n),
		.bypass_out    (bd_byp)
	);

	// Divide by the distance; drop the quotient when the bypass word wins.
	lcg_div #(.COORD_BITS(COORD_BITS)) u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (bd_valid),
		.in_ready    (bd_ready),
		.rem         (bd_rem),
		.under       (bd_under & {NCH{bd_blend_n}}),
		.over        (bd_over & {NCH{bd_blend_n}}),
		.dist_mag    (bd_dist),
		.bypass      (bd_byp),
		.out_valid   (dv_valid),
		.out_ready   (pixel_out.ready),
		.pixel_color (dv_color)
	);

	assign pixel_out.valid       = dv_valid;
	assign pixel_out.pixel_color = dv_color;

endmodule

`default_nettype wire

/* design/lcg_front.sv */
// Front stages: coordinate deltas, major axis choice and sign normalization.
`default_nettype none

module lcg_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [COORD_BITS-1:0]      pixel_x,
	input  logic signed [COORD_BITS-1:0]      pixel_y,
	input  logic signed [COORD_BITS-1:0]      start_x,
	input  logic signed [COORD_BITS-1:0]      start_y,
	input  logic signed [COORD_BITS-1:0]      end_x,
	input  logic signed [COORD_BITS-1:0]      end_y,
	input  lcg_pkg::color_t                   start_color,
	input  lcg_pkg::color_t                   end_color,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [COORD_BITS:0]               dist_mag,
	output logic signed [COORD_BITS+1:0]      pos_adj,
	output logic [lcg_pkg::CH_BITS-1:0]       start_ch [lcg_pkg::CH_COUNT],
	output logic signed [lcg_pkg::CH_BITS:0]  diff_ch [lcg_pkg::CH_COUNT],
	output lcg_pkg::bypass_t                  bypass
);

	localparam int CW  = COORD_BITS + 1;
	localparam int MSB = COORD_BITS - 1;

	// stage 1
	logic                         v_s1;
	logic [CW-1:0]                dx_s1, dy_s1, px_s1, py_s1;
	lcg_pkg::color_t              sc_s1, ec_s1;
	logic                         eq_s1;
	logic [lcg_pkg::CH_BITS:0]    diff_s1 [lcg_pkg::CH_COUNT];
	logic [lcg_pkg::CH_BITS:0]    diff_d  [lcg_pkg::CH_COUNT];
	logic [CW-1:0]                dx_d, dy_d, px_d, py_d;

	// stage 2
	logic                         v_s2;
	logic [CW-1:0]                dmag_s2;
	logic [CW:0]                  padj_s2;
	logic [lcg_pkg::CH_BITS-1:0]  sch_s2  [lcg_pkg::CH_COUNT];
	logic [lcg_pkg::CH_BITS:0]    diff_s2 [lcg_pkg::CH_COUNT];
	lcg_pkg::bypass_t             byp_s2;

	logic [CW-1:0]                ax, ay, pos_sel, dist_sel, dmag_d;
	logic [CW:0]                  pos_ext, padj_d;
	logic                         use_x, dneg, dzero;
	lcg_pkg::bypass_t             byp_d;
	logic                         rdy1, rdy2;

	assign rdy2     = !v_s2 || out_ready;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	assign dx_d = {end_x[MSB], end_x} - {start_x[MSB], start_x};
	assign dy_d = {end_y[MSB], end_y} - {start_y[MSB], start_y};
	assign px_d = {pixel_x[MSB], pixel_x} - {start_x[MSB], start_x};
	assign py_d = {pixel_y[MSB], pixel_y} - {start_y[MSB], start_y};

	always_comb begin
		for (int c = 0; c < lcg_pkg::CH_COUNT; c++) begin
			diff_d[c] = {1'b0, end_color[lcg_pkg::chan_lsb(c) +: lcg_pkg::CH_BITS]}
				- {1'b0, start_color[lcg_pkg::chan_lsb(c) +: lcg_pkg::CH_BITS]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			dx_s1   <= dx_d;
			dy_s1   <= dy_d;
			px_s1   <= px_d;
			py_s1   <= py_d;
			sc_s1   <= start_color;
			ec_s1   <= end_color;
			eq_s1   <= (start_color == end_color);
			diff_s1 <= diff_d;
		end
	end

	// x wins only on a strictly larger span
	always_comb begin
		ax       = dx_s1[CW-1] ? -dx_s1 : dx_s1;
		ay       = dy_s1[CW-1] ? -dy_s1 : dy_s1;
		use_x    = ax > ay;
		pos_sel  = use_x ? px_s1 : py_s1;
		dist_sel = use_x ? dx_s1 : dy_s1;
		dneg     = dist_sel[CW-1];
		dzero    = (dist_sel == '0);
		dmag_d   = dneg ? -dist_sel : dist_sel;
		pos_ext  = {pos_sel[CW-1], pos_sel};
		padj_d   = dneg ? -pos_ext : pos_ext;
		byp_d.en   = eq_s1 || dzero;
		byp_d.word = eq_s1 ? sc_s1
			: {ec_s1[lcg_pkg::COLOR_BITS-1:lcg_pkg::CH_BITS], lcg_pkg::ALPHA_OPAQUE};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			dmag_s2 <= dmag_d;
			padj_s2 <= padj_d;
			diff_s2 <= diff_s1;
			byp_s2  <= byp_d;
			for (int c = 0; c < lcg_pkg::CH_COUNT; c++) begin
				sch_s2[c] <= sc_s1[lcg_pkg::chan_lsb(c) +: lcg_pkg::CH_BITS];
			end
		end
	end

	assign out_valid = v_s2;
	assign dist_mag  = dmag_s2;
	assign pos_adj   = $signed(padj_s2);
	assign start_ch  = sch_s2;
	assign bypass    = byp_s2;

	always_comb begin
		for (int c = 0; c < lcg_pkg::CH_COUNT; c++) begin
			diff_ch[c] = $signed(diff_s2[c]);
		end
	end

endmodule

`default_nettype wire

/* design/lcg_blend.sv */
// Blend stages: per-channel products, numerator sum and range flags.
`default_nettype none

module lcg_blend #(
	parameter int COORD_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [COORD_BITS:0]               dist_mag,
	input  logic signed [COORD_BITS+1:0]      pos_adj,
	input  logic [lcg_pkg::CH_BITS-1:0]       start_ch [lcg_pkg::CH_COUNT],
	input  logic signed [lcg_pkg::CH_BITS:0]  diff_ch [lcg_pkg::CH_COUNT],
	input  lcg_pkg::bypass_t                  bypass,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [COORD_BITS+8:0]             rem [lcg_pkg::CH_COUNT],
	output logic [lcg_pkg::CH_COUNT-1:0]      under,
	output logic [lcg_pkg::CH_COUNT-1:0]      over,
	output logic [COORD_BITS:0]               dist_out,
	output logic                              dist_unused_n,
	output lcg_pkg::bypass_t                  bypass_out
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = DW + lcg_pkg::CH_BITS;        // s * D and the remainder
	localparam int QW = COORD_BITS + 2 + lcg_pkg::CH_BITS + 1; // diff * P
	localparam int NW = QW + 1;                       // numerator

	logic                  v_s3, v_s4;
	logic [PW-1:0]         pa_s3 [lcg_pkg::CH_COUNT];
	logic signed [QW-1:0]  pb_s3 [lcg_pkg::CH_COUNT];
	logic [DW-1:0]         d_s3, d_s4;
	lcg_pkg::bypass_t      byp_s3, byp_s4;
	logic [PW-1:0]         rem_s4 [lcg_pkg::CH_COUNT];
	logic [lcg_pkg::CH_COUNT-1:0] under_s4, over_s4;

	logic [PW-1:0]         pa_d [lcg_pkg::CH_COUNT];
	logic signed [QW-1:0]  pb_d [lcg_pkg::CH_COUNT];
	logic [NW-1:0]         num  [lcg_pkg::CH_COUNT];
	logic [PW-1:0]         rem_d [lcg_pkg::CH_COUNT];
	logic [lcg_pkg::CH_COUNT-1:0] under_d, over_d;
	logic [NW-1:0]         lim;
	logic                  rdy3, rdy4;

	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign in_ready = rdy3;

	// numerator = s*D + (e - s)*P, which equals s*(D-P) + e*P
	always_comb begin
		for (int c = 0; c < lcg_pkg::CH_COUNT; c++) begin
			pa_d[c] = {{DW{1'b0}}, start_ch[c]} * {{lcg_pkg::CH_BITS{1'b0}}, dist_mag};
			pb_d[c] = $signed({{(QW-lcg_pkg::CH_BITS-1){diff_ch[c][lcg_pkg::CH_BITS]}},
				diff_ch[c]})
				* $signed({{(QW-DW-1){pos_adj[COORD_BITS+1]}}, pos_adj});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy3) begin
				v_s3 <= in_valid;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && in_valid) begin
			pa_s3  <= pa_d;
			pb_s3  <= pb_d;
			d_s3   <= dist_mag;
			byp_s3 <= bypass;
		end
	end

	// Flag below zero and at or above 256; otherwise the remainder fits PW bits.
	assign lim = {{(NW-PW){1'b0}}, d_s3, {lcg_pkg::CH_BITS{1'b0}}};

	always_comb begin
		for (int c = 0; c < lcg_pkg::CH_COUNT; c++) begin
			num[c]     = {{(NW-PW){1'b0}}, pa_s3[c]} + {pb_s3[c][QW-1], pb_s3[c]};
			under_d[c] = num[c][NW-1];
			over_d[c]  = !num[c][NW-1] && (num[c] >= lim);
			rem_d[c]   = num[c][PW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			rem_s4   <= rem_d;
			under_s4 <= under_d;
			over_s4  <= over_d;
			d_s4     <= d_s3;
			byp_s4   <= byp_s3;
		end
	end

	assign out_valid     = v_s4;
	assign rem           = rem_s4;
	assign under         = under_s4;
	assign over          = over_s4;
	assign dist_out      = d_s4;
	assign dist_unused_n = !byp_s4.en;
	assign bypass_out    = byp_s4;

endmodule

`default_nettype wire

/* design/lcg_div.sv */
// Divider pipeline: one quotient bit per stage, then clamp and pack the color.
`default_nettype none

module lcg_div #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [COORD_BITS+8:0]         rem [lcg_pkg::CH_COUNT],
	input  logic [lcg_pkg::CH_COUNT-1:0]  under,
	input  logic [lcg_pkg::CH_COUNT-1:0]  over,
	input  logic [COORD_BITS:0]           dist_mag,
	input  lcg_pkg::bypass_t              bypass,
	output logic                          out_valid,
	input  logic                          out_ready,
	output lcg_pkg::color_t               pixel_color
);

	localparam int DW    = COORD_BITS + 1;
	localparam int PW    = DW + lcg_pkg::CH_BITS;
	localparam int STEPS = lcg_pkg::QUO_BITS;
	localparam int NCH   = lcg_pkg::CH_COUNT;

	// stage k of the divider holds the partial remainder and quotient
	logic                          v_sk     [STEPS];
	logic [PW-1:0]                 rem_sk   [STEPS][NCH];
	logic [lcg_pkg::QUO_BITS-1:0]  quo_sk   [STEPS][NCH];
	logic [NCH-1:0]                under_sk [STEPS];
	logic [NCH-1:0]                over_sk  [STEPS];
	logic [DW-1:0]                 d_sk     [STEPS];
	lcg_pkg::bypass_t              byp_sk   [STEPS];
	logic                          rdy      [STEPS+1];

	logic                          out_v_q;
	lcg_pkg::color_t               color_q;
	lcg_pkg::color_t               color_d;

	assign rdy[STEPS] = !out_v_q || out_ready;
	assign in_ready   = rdy[0];

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		localparam int K = STEPS - 1 - j;

		logic                          st_v;
		logic [PW-1:0]                 st_rem [NCH];
		logic [lcg_pkg::QUO_BITS-1:0]  st_quo [NCH];
		logic [NCH-1:0]                st_under, st_over;
		logic [DW-1:0]                 st_d;
		lcg_pkg::bypass_t              st_byp;
		logic [PW-1:0]                 dsh;
		logic [PW-1:0]                 nrem [NCH];
		logic [lcg_pkg::QUO_BITS-1:0]  nquo [NCH];
		logic                          ge;

		if (j == 0) begin : g_head
			assign st_v     = in_valid;
			assign st_rem   = rem;
			assign st_under = under;
			assign st_over  = over;
			assign st_d     = dist_mag;
			assign st_byp   = bypass;
			always_comb begin
				for (int c = 0; c < NCH; c++) begin
					st_quo[c] = '0;
				end
			end
		end else begin : g_body
			assign st_v     = v_sk[j-1];
			assign st_rem   = rem_sk[j-1];
			assign st_quo   = quo_sk[j-1];
			assign st_under = under_sk[j-1];
			assign st_over  = over_sk[j-1];
			assign st_d     = d_sk[j-1];
			assign st_byp   = byp_sk[j-1];
		end

		assign dsh    = {{lcg_pkg::CH_BITS{1'b0}}, st_d} << K;
		assign rdy[j] = !v_sk[j] || rdy[j+1];

		// restoring step: take D*2^K out when it fits
		always_comb begin
			ge = 1'b0;
			for (int c = 0; c < NCH; c++) begin
				ge      = (st_rem[c] >= dsh);
				nrem[c] = ge ? (st_rem[c] - dsh) : st_rem[c];
				nquo[c] = st_quo[c] | ({{(lcg_pkg::QUO_BITS-1){1'b0}}, ge} << K);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk[j] <= 1'b0;
			end else if (rdy[j]) begin
				v_sk[j] <= st_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[j] && st_v) begin
				rem_sk[j]   <= nrem;
				quo_sk[j]   <= nquo;
				under_sk[j] <= st_under;
				over_sk[j]  <= st_over;
				d_sk[j]     <= st_d;
				byp_sk[j]   <= st_byp;
			end
		end
	end

	// clamp each channel, then let the bypass word override
	always_comb begin
		color_d = {{(lcg_pkg::COLOR_BITS-lcg_pkg::CH_BITS){1'b0}}, lcg_pkg::ALPHA_OPAQUE};
		for (int c = 0; c < NCH; c++) begin
			if (under_sk[STEPS-1][c]) begin
				color_d[lcg_pkg::chan_lsb(c) +: lcg_pkg::CH_BITS] = lcg_pkg::CH_MIN;
			end else if (over_sk[STEPS-1][c]) begin
				color_d[lcg_pkg::chan_lsb(c) +: lcg_pkg::CH_BITS] = lcg_pkg::CH_MAX;
			end else begin
				color_d[lcg_pkg::chan_lsb(c) +: lcg_pkg::CH_BITS] = quo_sk[STEPS-1][c];
			end
		end
		if (byp_sk[STEPS-1].en) begin
			color_d = byp_sk[STEPS-1].word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (rdy[STEPS]) begin
			out_v_q <= v_sk[STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[STEPS] && v_sk[STEPS-1]) begin
			color_q <= color_d;
		end
	end

	assign out_valid   = out_v_q;
	assign pixel_color = color_q;

endmodule

`default_nettype wire

/* design/lcg_checker.sv */
// Port-level checks on the line color gradient, bound to the top level.
`default_nettype none

module lcg_checker #(
	parameter int DEPTH = 13
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input lcg_pkg::color_t       out_color
);

	localparam int CNT_W = $clog2(DEPTH + 1) + 1;

	logic             in_fire, out_fire;
	logic [CNT_W-1:0] count_q;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_fire && !out_fire) begin
			count_q <= count_q + 1'b1;
		end else if (out_fire && !in_fire) begin
			count_q <= count_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_color))
		else $error("output word changed while stalled");

	a_ready_pass: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input not ready while output drains");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> !out_valid)
		else $error("output word with nothing in flight");

	// every slot full and the output held: block the input
	a_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'(DEPTH) && !out_ready |-> !in_ready)
		else $error("pipeline accepted beyond its depth");

endmodule

bind line_color_gradient lcg_checker #(.DEPTH(13)) u_lcg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixel_in.valid),
	.in_ready  (pixel_in.ready),
	.out_valid (pixel_out.valid),
	.out_ready (pixel_out.ready),
	.out_color (pixel_out.pixel_color)
);

`default_nettype wire
